>>> rtl/core/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the proximity trigger table.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    // Result queue depth; also the number of reads allowed in flight.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [15:0] DIST_CLEARED = 16'hffff;
    localparam logic [15:0] DIST_MAX     = 16'hfffe;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_UPDATE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // One stored trigger, 64 bits.
    typedef struct packed {
        logic [7:0]  hid;
        logic [7:0]  tc;
        logic [7:0]  tb;
        logic [7:0]  ta;
        logic [15:0] py;
        logic [15:0] px;
    } trig_entry_t;

    // Per-read control that travels alongside the memory data.
    typedef struct packed {
        logic clear;
        logic last;
    } walk_meta_t;

    // One report.
    typedef struct packed {
        logic        last;
        logic [7:0]  hid;
        logic [7:0]  tc;
        logic [7:0]  tb;
        logic [7:0]  ta;
        logic [15:0] distance;
    } report_t;

endpackage

>>> rtl/core/ptt_store.sv
// ----------------------------------------------------------------------------
// ptt_store
// Trigger memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ptt_store
    import ptt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  trig_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output trig_entry_t       rd_data
);

    trig_entry_t mem [0:TABLE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/ptt_dist.sv
// ----------------------------------------------------------------------------
// ptt_dist
// Two-stage distance pipeline: absolute differences, then max plus half min
// with saturation. A clear request bypasses the arithmetic.
// ----------------------------------------------------------------------------
module ptt_dist
    import ptt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  walk_meta_t        in_meta,
    input  trig_entry_t       in_entry,
    input  logic [15:0]       query_x,
    input  logic [15:0]       query_y,
    output logic              out_valid,
    output report_t           out_report
);

    logic signed [16:0] diff_x;
    logic signed [16:0] diff_y;
    logic [15:0]        mag_x;
    logic [15:0]        mag_y;

    logic               s1_valid_reg;
    walk_meta_t         s1_meta_reg;
    trig_entry_t        s1_entry_reg;
    logic [15:0]        s1_mag_x_reg;
    logic [15:0]        s1_mag_y_reg;

    logic [15:0]        big;
    logic [15:0]        half_small;
    logic [16:0]        sum;
    logic [15:0]        dist_value;

    logic               s2_valid_reg;
    report_t            s2_report_reg;

    // Differences are exact in 17 bits, so magnitudes fit in 16.
    assign diff_x = $signed({query_x[15], query_x}) - $signed({in_entry.px[15], in_entry.px});
    assign diff_y = $signed({query_y[15], query_y}) - $signed({in_entry.py[15], in_entry.py});
    assign mag_x  = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
    assign mag_y  = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        s1_meta_reg  <= in_meta;
        s1_entry_reg <= in_entry;
        s1_mag_x_reg <= mag_x;
        s1_mag_y_reg <= mag_y;
    end

    assign big        = (s1_mag_x_reg > s1_mag_y_reg) ? s1_mag_x_reg : s1_mag_y_reg;
    assign half_small = ((s1_mag_x_reg > s1_mag_y_reg) ? s1_mag_y_reg : s1_mag_x_reg) >> 1;
    assign sum        = {1'b0, big} + {1'b0, half_small};

    always_comb begin
        if (s1_meta_reg.clear) begin
            dist_value = DIST_CLEARED;
        end else if (sum > {1'b0, DIST_MAX}) begin
            dist_value = DIST_MAX;
        end else begin
            dist_value = sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_report_reg.distance <= dist_value;
        s2_report_reg.ta       <= s1_entry_reg.ta;
        s2_report_reg.tb       <= s1_entry_reg.tb;
        s2_report_reg.tc       <= s1_entry_reg.tc;
        s2_report_reg.hid      <= s1_entry_reg.hid;
        s2_report_reg.last     <= s1_meta_reg.last;
    end

    assign out_valid  = s2_valid_reg;
    assign out_report = s2_report_reg;

endmodule

>>> rtl/core/ptt_out_queue.sv
// ----------------------------------------------------------------------------
// ptt_out_queue
// Small report queue in front of the result channel. The controller never
// has more reads in flight than there are free slots, so a push is never
// refused.
// ----------------------------------------------------------------------------
module ptt_out_queue
    import ptt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  report_t           push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output report_t           pop_data
);

    report_t               slot [0:OUT_DEPTH-1];
    logic [OUT_PTR_W-1:0]  wr_ptr_reg;
    logic [OUT_PTR_W-1:0]  wr_ptr_next;
    logic [OUT_PTR_W-1:0]  rd_ptr_reg;
    logic [OUT_PTR_W-1:0]  rd_ptr_next;
    logic [OUT_CNT_W-1:0]  fill_reg;
    logic [OUT_CNT_W-1:0]  fill_next;
    logic                  pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (fill_reg != '0);
    assign pop_data  = slot[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/proximity_trigger_table_unit.sv
// ----------------------------------------------------------------------------
// proximity_trigger_table_unit
// Trigger table with add, distance report and clear requests.
// ----------------------------------------------------------------------------
// An add gives no report. An update or clear over n entries reads one entry a cycle
// while the four-slot report queue has room; a slot frees when its report is taken,
// and the next request is taken once the walk has issued its last read. The first
// report passes the read, two distance stages and the queue; a stalled result
// channel holds the walk. Reset empties the table at once.
// ----------------------------------------------------------------------------
module proximity_trigger_table_unit
    import ptt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x[15:0], pos_y[31:16], tag_a[39:32], tag_b[47:40], tag_c[55:48],
    // handler_id[63:56]
    input  logic [63:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // distance[15:0], out_tag_a[23:16], out_tag_b[31:24], out_tag_c[39:32],
    // out_handler[47:40]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    walk_idx_reg;
    logic [CNT_W-1:0]    walk_idx_next;
    logic [CNT_W-1:0]    walk_n_reg;
    logic [CNT_W-1:0]    walk_n_next;
    logic                walk_clear_reg;
    logic                walk_clear_next;
    logic [15:0]         query_x_reg;
    logic [15:0]         query_x_next;
    logic [15:0]         query_y_reg;
    logic [15:0]         query_y_next;
    logic [OUT_CNT_W-1:0] inflight_reg;
    logic [OUT_CNT_W-1:0] inflight_next;
    logic                meta_valid_reg;
    walk_meta_t          meta_reg;

    op_t                 op;
    logic                accept;
    logic                do_add;
    logic                start_walk;
    logic                walk_last;
    logic                rd_issue;
    logic                pop;
    trig_entry_t         new_entry;
    trig_entry_t         rd_entry;
    logic                rep_valid;
    report_t             rep;
    report_t             out_rep;

    assign op         = op_t'(s_axis_tuser);
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign do_add     = accept && (op == OP_ADD) && (s_axis_tdata[63:56] != 8'd0)
                        && (count_reg < CNT_W'(TABLE_DEPTH));
    assign start_walk = accept && ((op == OP_UPDATE) || (op == OP_CLEAR))
                        && (count_reg != '0);
    assign walk_last  = ((walk_idx_reg + 1'b1) == walk_n_reg);
    assign pop        = m_axis_tvalid && m_axis_tready;

    assign new_entry.px  = s_axis_tdata[15:0];
    assign new_entry.py  = s_axis_tdata[31:16];
    assign new_entry.ta  = s_axis_tdata[39:32];
    assign new_entry.tb  = s_axis_tdata[47:40];
    assign new_entry.tc  = s_axis_tdata[55:48];
    assign new_entry.hid = s_axis_tdata[63:56];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_walk) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (rd_issue && walk_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        rd_issue      = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_WALK: rd_issue = (inflight_reg < OUT_CNT_W'(OUT_DEPTH));
            default: begin
                s_axis_tready = 1'b0;
                rd_issue      = 1'b0;
            end
        endcase
    end

    always_comb begin
        count_next      = count_reg;
        walk_idx_next   = walk_idx_reg;
        walk_n_next     = walk_n_reg;
        walk_clear_next = walk_clear_reg;
        query_x_next    = query_x_reg;
        query_y_next    = query_y_reg;
        if (do_add) begin
            count_next = count_reg + 1'b1;
        end
        if (start_walk) begin
            walk_idx_next   = '0;
            walk_n_next     = count_reg;
            walk_clear_next = (op == OP_CLEAR);
            query_x_next    = s_axis_tdata[15:0];
            query_y_next    = s_axis_tdata[31:16];
            // The memory keeps its contents, so the walk still reads them.
            if (op == OP_CLEAR) begin
                count_next = '0;
            end
        end else if (rd_issue) begin
            walk_idx_next = walk_idx_reg + 1'b1;
        end
        inflight_next = inflight_reg + OUT_CNT_W'(rd_issue) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            inflight_reg   <= '0;
            meta_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            inflight_reg   <= inflight_next;
            meta_valid_reg <= rd_issue;
        end
    end

    always_ff @(posedge aclk) begin
        walk_idx_reg   <= walk_idx_next;
        walk_n_reg     <= walk_n_next;
        walk_clear_reg <= walk_clear_next;
        query_x_reg    <= query_x_next;
        query_y_reg    <= query_y_next;
        meta_reg.clear <= walk_clear_reg;
        meta_reg.last  <= walk_last;
    end

    ptt_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (do_add),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (new_entry),
        .rd_en   (rd_issue),
        .rd_addr (walk_idx_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    ptt_dist u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (meta_valid_reg),
        .in_meta    (meta_reg),
        .in_entry   (rd_entry),
        .query_x    (query_x_reg),
        .query_y    (query_y_reg),
        .out_valid  (rep_valid),
        .out_report (rep)
    );

    ptt_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rep_valid),
        .push_data (rep),
        .pop_valid (m_axis_tvalid),
        .pop_ready (m_axis_tready),
        .pop_data  (out_rep)
    );

    assign m_axis_tdata = {out_rep.hid, out_rep.tc, out_rep.tb, out_rep.ta, out_rep.distance};
    assign m_axis_tlast = out_rep.last;

    // Reads in flight never exceed the report queue's depth.
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("more reads in flight than queue slots");

    // A report can only be offered while its read is still counted.
    a_report_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (inflight_reg != '0))
        else $error("report offered without a read in flight");

    // A clear request empties the table for the following request.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (op == OP_CLEAR)) |=> (count_reg == '0))
        else $error("table not empty after clear");

    // The walk never reads past the entries that were filled.
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_issue |-> (walk_idx_reg < walk_n_reg))
        else $error("walk read beyond filled entries");

endmodule
